/* design/itdt_pkg.sv */
// Shared constants, types and helpers for the integer to decimal text block.
`timescale 1ns / 1ps

package itdt_pkg;

  // Width of the input field as it stands on the port.
  localparam int unsigned IN_BITS = 32;
  // Width of the two's complement value that is converted.
  localparam int unsigned VALUE_BITS = 32;

  // Count the decimal digits of the largest magnitude, 2^(bits-1).
  function automatic int unsigned digits_for(int unsigned bits);
    longint unsigned m;
    int unsigned     n;
    m = 64'd1 << (bits - 1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (m != 0) begin
        m = m / 10;
        n = n + 1;
      end
    end
    return n;
  endfunction

  localparam int unsigned NUM_DIGITS = digits_for(VALUE_BITS);
  localparam int unsigned DIG_W      = 4;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned REM_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);

  // Operation applied to every cell of the digit chain at once.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_e;

endpackage

/* design/itdt_intf.sv */
// Stream interfaces for integer requests and character results.
`timescale 1ns / 1ps

interface itdt_value_if;
  import itdt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [IN_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itdt_char_if;
  import itdt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              last;

  modport source (output valid, output text_char, output last, input ready);
  modport sink   (input valid, input text_char, input last, output ready);
endinterface

/* design/itdt_digit_cell.sv */
// One BCD digit cell of the shift-add-3 conversion chain.
`timescale 1ns / 1ps

module itdt_digit_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  itdt_pkg::cell_op_e    op_i,
  input  logic                  bit_i,
  input  logic [itdt_pkg::DIG_W-1:0] dig_i,
  output logic                  bit_o,
  output logic [itdt_pkg::DIG_W-1:0] dig_o
);
  import itdt_pkg::*;

  logic [DIG_W-1:0] dig_q, dig_d, adj;

  // Add 3 to digits of five and up so the next doubling carries correctly.
  assign adj   = (dig_q >= DIG_W'(5)) ? dig_q + DIG_W'(3) : dig_q;
  assign bit_o = adj[DIG_W-1];
  assign dig_o = dig_q;

  always_comb begin
    unique case (op_i)
      CELL_HOLD:   dig_d = dig_q;
      CELL_CLEAR:  dig_d = '0;
      CELL_DABBLE: dig_d = {adj[DIG_W-2:0], bit_i};
      CELL_SHIFT:  dig_d = dig_i;
      default:     dig_d = dig_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q <= '0;
    end else begin
      dig_q <= dig_d;
    end
  end

endmodule

/* design/integer_to_decimal_text.sv */
// Top level: signed integer to ASCII decimal text over a chain of BCD cells.
`timescale 1ns / 1ps

//  channel  | dir | payload                    | handshake
//  req_i    | in  | value (32 b, signed)       | valid/ready, one request per integer
//  txt_o    | out | text_char (6 b), last      | valid/ready, one per character
//
// A request is taken only in idle. During conversion the magnitude shifts in
// one bit a cycle through the chain of digit cells. Leading zeros are then
// dropped one at a time, the skip state is left, and each character is held
// on the output register until it is taken. A request passes through accept,
// conversion, dropping of leading zeros, leaving the skip state, the sign when
// negative and then the digits, and the last digit returns the block to idle.
// Reset is asynchronous, active low, and returns the block to idle with no
// character pending. A stalled output holds the character; while the sign or
// the digits are emitted it also freezes the chain.

module integer_to_decimal_text (
  input  logic             clk_i,
  input  logic             rst_ni,
  itdt_value_if.sink       req_i,
  itdt_char_if.source      txt_o
);
  import itdt_pkg::*;

  state_e                  state_q, state_d;
  logic [BIT_CNT_W-1:0]    cnt_q, cnt_d;
  logic [REM_W-1:0]        rem_q, rem_d;
  logic                    neg_q, neg_d;
  logic [VALUE_BITS-1:0]   mag_q, mag_d;
  logic                    out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]       out_char_q, out_char_d;
  logic                    out_last_q, out_last_d;

  logic [VALUE_BITS-1:0]   v_in, mag_in;
  logic                    neg_in, out_free;
  cell_op_e                cell_op;

  logic [NUM_DIGITS:0]     carry;
  logic [DIG_W-1:0]        dig [NUM_DIGITS];
  logic [DIG_W-1:0]        top_dig;

  // Keep only the low VALUE_BITS bits; negate into an unsigned magnitude so
  // the most negative value comes out as 2^(VALUE_BITS-1).
  assign v_in   = VALUE_BITS'($unsigned(req_i.value));
  assign neg_in = v_in[VALUE_BITS-1];
  assign mag_in = neg_in ? (~v_in + VALUE_BITS'(1)) : v_in;

  // Cell 0 is the least significant digit; the magnitude enters MSB first.
  assign carry[0] = mag_q[VALUE_BITS-1];
  assign top_dig  = dig[NUM_DIGITS-1];

  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    logic [DIG_W-1:0] below;
    if (g == 0) begin : g_bottom
      assign below = '0;
    end else begin : g_upper
      assign below = dig[g-1];
    end
    itdt_digit_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (cell_op),
      .bit_i  (carry[g]),
      .dig_i  (below),
      .bit_o  (carry[g+1]),
      .dig_o  (dig[g])
    );
  end

  assign out_free = !out_valid_q || txt_o.ready;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    cell_op     = CELL_HOLD;
    out_valid_d = out_valid_q && !txt_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          cell_op = CELL_CLEAR;
          mag_d   = mag_in;
          neg_d   = neg_in;
          cnt_d   = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        // Double-dabble one bit per cycle.
        cell_op = CELL_DABBLE;
        mag_d   = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d   = cnt_q + BIT_CNT_W'(1);
        if (cnt_q == BIT_CNT_W'(VALUE_BITS - 1)) begin
          rem_d   = REM_W'(NUM_DIGITS);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros but always keep the last digit.
        if (top_dig == '0 && rem_q != REM_W'(1)) begin
          cell_op = CELL_SHIFT;
          rem_d   = rem_q - REM_W'(1);
        end else begin
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = ASCII_MINUS;
          out_last_d  = 1'b0;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = ASCII_ZERO + CHAR_W'(top_dig);
          out_last_d  = (rem_q == REM_W'(1));
          cell_op     = CELL_SHIFT;
          rem_d       = rem_q - REM_W'(1);
          if (rem_q == REM_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    mag_q      <= mag_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign req_i.ready     = (state_q == ST_IDLE);
  assign txt_o.valid     = out_valid_q;
  assign txt_o.text_char = out_char_q;
  assign txt_o.last      = out_last_q;

endmodule
